@@ rtl/heap_sort_with_op_counters_core_macros.svh @@
// assertion macros for the heap sort core
`ifndef HEAP_SORT_WITH_OP_COUNTERS_CORE_MACROS_SVH
`define HEAP_SORT_WITH_OP_COUNTERS_CORE_MACROS_SVH

`ifndef SYNTHESIS

`define HSOC_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("heap sort core: check failed");

`define HSOC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("heap sort core: check failed");

`else

`define HSOC_ASSERT_NOW(label, clk, rst, ante, cons)

`define HSOC_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

@@ rtl/hsoc_pkg.sv @@
// shared types and constants for the heap sort core
package hsoc_pkg;

   localparam int CAPACITY_DEFAULT = 64;
   localparam int VALUE_W          = 32;
   localparam int TOTAL_W          = 32;

   localparam logic [1:0] CMP_EXTRACT   = 2'd1;
   localparam logic [1:0] CMP_SIFT_UP   = 2'd2;
   localparam logic [1:0] CMP_SIFT_DOWN = 2'd3;

   typedef struct packed {
      logic signed [VALUE_W-1:0] sample_value;
      logic                      is_final;
   } req_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] sorted_value;
      logic                      end_of_run;
      logic [TOTAL_W-1:0]        compare_total;
      logic [TOTAL_W-1:0]        swap_total;
      logic                      overflowed;
   } rsp_type;

   typedef struct packed {
      logic [1:0] cmp_add;
      logic       swap_inc;
   } ctr_evt_type;

endpackage

@@ rtl/hsoc_op_counters.sv @@
// cumulative compare and swap counters
module hsoc_op_counters
   import hsoc_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  ctr_evt_type        evt,
   output logic [TOTAL_W-1:0] compare_total,
   output logic [TOTAL_W-1:0] swap_total
);

   logic [TOTAL_W-1:0] compare_ff, compare_in;
   logic [TOTAL_W-1:0] swap_ff, swap_in;

   always_comb begin
      compare_in = compare_ff + TOTAL_W'(evt.cmp_add);
      swap_in    = swap_ff + TOTAL_W'(evt.swap_inc);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         compare_ff <= '0;
         swap_ff    <= '0;
      end else begin
         compare_ff <= compare_in;
         swap_ff    <= swap_in;
      end
   end

   assign compare_total = compare_ff;
   assign swap_total    = swap_ff;

endmodule

@@ rtl/heap_sort_with_op_counters_core.sv @@
// heap sort core: element store, build and extraction sequencer, result stream
//
// Values load one per cycle while busy is low; the transfer marked is_final starts the
// sort and busy stays high until the last result has gone out. Building the heap sifts
// each element up one level per compare, and each extraction swaps the root with the
// last element and sifts it down one level per compare; the pace of both is bounded by
// the single-write, dual-read element memory. Results then follow one per
// cycle in ascending order, each on rsp_payload for exactly one cycle under rsp_strobe;
// the receiver cannot stall, so it must take every strobed cycle. Values beyond
// CAPACITY are dropped and flagged in overflowed. The counters run from reset on.
`include "heap_sort_with_op_counters_core_macros.svh"

module heap_sort_with_op_counters_core
   import hsoc_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEFAULT
)
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_payload,
   output logic    rsp_strobe,
   output rsp_type rsp_payload
);

   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int CH_W  = IDX_W + 1;
   localparam logic [CNT_W-1:0] CAP_COUNT = CNT_W'(CAPACITY);

   localparam logic [3:0] ST_IDLE     = 4'd0;
   localparam logic [3:0] ST_BU_START = 4'd1;
   localparam logic [3:0] ST_BU_CMP   = 4'd2;
   localparam logic [3:0] ST_BU_PLACE = 4'd3;
   localparam logic [3:0] ST_EX_START = 4'd4;
   localparam logic [3:0] ST_EX_SWAP  = 4'd5;
   localparam logic [3:0] ST_SD_CMP   = 4'd6;
   localparam logic [3:0] ST_OUT_RD   = 4'd7;
   localparam logic [3:0] ST_FINISH   = 4'd8;

   logic [3:0]                state_ff, state_in;
   logic [CNT_W-1:0]          count_ff, count_in;
   logic                      dropped_ff, dropped_in;
   logic [CNT_W-1:0]          k_ff, k_in;
   logic [CNT_W-1:0]          last_ff, last_in;
   logic [IDX_W-1:0]          pos_ff, pos_in;
   logic signed [VALUE_W-1:0] x_ff, x_in;
   logic                      first_ff, first_in;
   logic                      out_vld_ff, out_vld_in;
   logic                      out_last_ff, out_last_in;

   logic [VALUE_W-1:0]        store_mem [CAPACITY];
   logic signed [VALUE_W-1:0] rd_a_ff, rd_b_ff;
   logic [IDX_W-1:0]          rd_a_addr, rd_b_addr, wr_addr;
   logic                      wr_en;
   logic [VALUE_W-1:0]        wr_data;

   logic                      accept;
   logic [IDX_W-1:0]          k_idx, k_parent, pos_parent, parent_parent;
   logic [CNT_W-1:0]          k_next;
   logic signed [VALUE_W-1:0] up_val;
   logic [CH_W-1:0]           left_ch, right_ch, last_ext, best_left, best_right;
   logic                      take_left, take_right;
   logic [IDX_W-1:0]          best_pos;
   logic signed [VALUE_W-1:0] left_best_val, best_val;
   ctr_evt_type               ctr_evt;
   logic [TOTAL_W-1:0]        compare_total, swap_total;

   assign accept = start && !busy;
   assign busy   = (state_ff != ST_IDLE);

   always_comb begin
      k_idx         = k_ff[IDX_W-1:0];
      k_next        = k_ff + CNT_W'(1);
      k_parent      = (k_idx - IDX_W'(1)) >> 1;
      pos_parent    = (pos_ff - IDX_W'(1)) >> 1;
      parent_parent = (pos_parent - IDX_W'(1)) >> 1;
      up_val        = first_ff ? rd_a_ff : x_ff;

      left_ch    = {pos_ff, 1'b1};
      right_ch   = left_ch + CH_W'(1);
      last_ext   = CH_W'(last_ff);
      take_left  = (left_ch < last_ext) && (rd_a_ff > x_ff);
      left_best_val = take_left ? rd_a_ff : x_ff;
      take_right = (right_ch < last_ext) && (rd_b_ff > left_best_val);
      best_pos   = take_right ? right_ch[IDX_W-1:0]
                 : (take_left ? left_ch[IDX_W-1:0] : pos_ff);
      best_val   = take_right ? rd_b_ff : left_best_val;
      best_left  = {best_pos, 1'b1};
      best_right = best_left + CH_W'(1);
   end

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      dropped_in  = dropped_ff;
      k_in        = k_ff;
      last_in     = last_ff;
      pos_in      = pos_ff;
      x_in        = x_ff;
      first_in    = first_ff;
      out_vld_in  = 1'b0;
      out_last_in = 1'b0;
      rd_a_addr   = '0;
      rd_b_addr   = '0;
      wr_en       = 1'b0;
      wr_addr     = '0;
      wr_data     = '0;
      ctr_evt     = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (count_ff != CAP_COUNT) begin
                  wr_en    = 1'b1;
                  wr_addr  = count_ff[IDX_W-1:0];
                  wr_data  = req_payload.sample_value;
                  count_in = count_ff + CNT_W'(1);
               end else begin
                  dropped_in = 1'b1;
               end
               if (req_payload.is_final) begin
                  k_in     = CNT_W'(1);
                  state_in = ST_BU_START;
               end
            end
         end
         ST_BU_START: begin
            if (k_ff == count_ff) begin
               last_in  = count_ff - CNT_W'(1);
               state_in = ST_EX_START;
            end else begin
               rd_a_addr = k_idx;
               rd_b_addr = k_parent;
               pos_in    = k_idx;
               first_in  = 1'b1;
               state_in  = ST_BU_CMP;
            end
         end
         ST_BU_CMP: begin
            ctr_evt.cmp_add = CMP_SIFT_UP;
            wr_en   = 1'b1;
            wr_addr = pos_ff;
            if (up_val > rd_b_ff) begin
               ctr_evt.swap_inc = 1'b1;
               wr_data   = rd_b_ff;
               x_in      = up_val;
               first_in  = 1'b0;
               pos_in    = pos_parent;
               rd_b_addr = parent_parent;
               if (pos_parent == '0) begin
                  state_in = ST_BU_PLACE;
               end
            end else begin
               wr_data  = up_val;
               k_in     = k_next;
               state_in = ST_BU_START;
            end
         end
         ST_BU_PLACE: begin
            wr_en    = 1'b1;
            wr_addr  = pos_ff;
            wr_data  = x_ff;
            k_in     = k_next;
            state_in = ST_BU_START;
         end
         ST_EX_START: begin
            if (last_ff == '0) begin
               k_in     = '0;
               state_in = ST_OUT_RD;
            end else begin
               rd_a_addr = '0;
               rd_b_addr = last_ff[IDX_W-1:0];
               state_in  = ST_EX_SWAP;
            end
         end
         ST_EX_SWAP: begin
            ctr_evt.cmp_add  = CMP_EXTRACT;
            ctr_evt.swap_inc = 1'b1;
            wr_en     = 1'b1;
            wr_addr   = last_ff[IDX_W-1:0];
            wr_data   = rd_a_ff;
            x_in      = rd_b_ff;
            pos_in    = '0;
            rd_a_addr = IDX_W'(1);
            rd_b_addr = IDX_W'(2);
            state_in  = ST_SD_CMP;
         end
         ST_SD_CMP: begin
            ctr_evt.cmp_add = CMP_SIFT_DOWN;
            wr_en   = 1'b1;
            wr_addr = pos_ff;
            if (take_left || take_right) begin
               ctr_evt.swap_inc = 1'b1;
               wr_data   = best_val;
               pos_in    = best_pos;
               rd_a_addr = best_left[IDX_W-1:0];
               rd_b_addr = best_right[IDX_W-1:0];
            end else begin
               wr_data  = x_ff;
               last_in  = last_ff - CNT_W'(1);
               state_in = ST_EX_START;
            end
         end
         ST_OUT_RD: begin
            rd_a_addr   = k_idx;
            out_vld_in  = 1'b1;
            out_last_in = (k_next == count_ff);
            k_in        = k_next;
            if (k_next == count_ff) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            count_in   = '0;
            dropped_in = 1'b0;
            state_in   = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         count_ff   <= '0;
         dropped_ff <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         dropped_ff <= dropped_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      k_ff        <= k_in;
      last_ff     <= last_in;
      pos_ff      <= pos_in;
      x_ff        <= x_in;
      first_ff    <= first_in;
      out_last_ff <= out_last_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[wr_addr] <= wr_data;
      end
      rd_a_ff <= store_mem[rd_a_addr];
      rd_b_ff <= store_mem[rd_b_addr];
   end

   hsoc_op_counters u_counters (
      .clock         (clock),
      .reset         (reset),
      .evt           (ctr_evt),
      .compare_total (compare_total),
      .swap_total    (swap_total)
   );

   assign rsp_strobe                = out_vld_ff;
   assign rsp_payload.sorted_value  = rd_a_ff;
   assign rsp_payload.end_of_run    = out_last_ff;
   assign rsp_payload.compare_total = compare_total;
   assign rsp_payload.swap_total    = swap_total;
   assign rsp_payload.overflowed    = dropped_ff;

   `HSOC_ASSERT_NOW(a_strobe_in_output, clock, reset, rsp_strobe, state_ff == ST_OUT_RD || state_ff == ST_FINISH)
   `HSOC_ASSERT_NOW(a_last_in_finish, clock, reset, rsp_strobe && rsp_payload.end_of_run, state_ff == ST_FINISH)
   `HSOC_ASSERT_NEXT(a_final_starts_build, clock, reset, accept && req_payload.is_final, state_ff == ST_BU_START)
   `HSOC_ASSERT_NOW(a_busy_has_set, clock, reset, busy, count_ff != '0)

endmodule
